// ===== rtl/assert_macros.svh =====
// assertion macros shared by the decoder rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, switched off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/brd_pkg.sv =====
// shared types and constants of the byterun1 row decoder
// no dependencies; imported by every module of the block
package brd_pkg;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_DECODE_MODE,
      CSR_CHUNK_LENGTH
   } csr_index_type;

   // decode modes
   localparam logic MODE_RAW      = 1'b0;
   localparam logic MODE_BYTERUN1 = 1'b1;

   // register reset values
   localparam logic [15:0] WIDTH_RESET  = 16'd320;
   localparam logic [15:0] HEIGHT_RESET = 16'd200;
   localparam logic        MODE_RESET   = MODE_BYTERUN1;
   localparam logic [31:0] CHUNK_RESET  = 32'd0;

   // no-op run header
   localparam logic [7:0] HDR_NOOP = 8'h80;

   // decoder phase
   typedef enum logic [1:0] {
      PH_DONE,
      PH_HEADER,
      PH_COPY,
      PH_VALUE
   } phase_type;

   typedef struct packed {
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        decode_mode;
      logic [31:0] chunk_length;
   } cfg_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] pixel_value;
      logic [7:0] repeat_count;
      logic       last_of_body;
   } rsp_type;

   // core status seen by the top level
   typedef struct packed {
      phase_type phase;
   } core_status_type;

   // output buffer occupancy
   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

// ===== rtl/brd_core.sv =====
// decoder core: run, row and budget counters, one byte per cycle while accept is high
// depends on brd_pkg
module brd_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     start_of_body,
   input  logic [7:0]               body_byte,
   input  brd_pkg::cfg_type         cfg,
   output logic                     res_valid,
   output brd_pkg::rsp_type         res,
   output brd_pkg::core_status_type status
);
   import brd_pkg::*;

   typedef struct packed {
      logic [31:0]        budget_left;
      logic signed [17:0] row_left;
      phase_type          phase;
      logic [7:0]         run_left;
      logic               drop_final;
      logic [15:0]        rows_left;
      logic [15:0]        column_left;
   } core_state_type;

   core_state_type state_ff, state_in;

   // working signals
   core_state_type     s_start;
   logic signed [17:0] row_eff;
   logic signed [17:0] row_new;
   logic [7:0]         run_len;
   logic [8:0]         cost;
   logic [31:0]        budget_new;
   logic [7:0]         run_dec;
   logic [15:0]        col_dec;
   logic [15:0]        rows_dec;
   logic               literal;

   // close a run: next header, or done when the budget is spent
   function automatic core_state_type end_run(core_state_type s);
      core_state_type r;
      r            = s;
      r.drop_final = 1'b0;
      r.run_left   = 8'd0;
      r.phase      = (s.budget_left != 32'd0) ? PH_HEADER : PH_DONE;
      return r;
   endfunction

   // close an uncompressed row
   function automatic core_state_type end_row(core_state_type s, logic [15:0] dec,
                                              logic [15:0] width);
      core_state_type r;
      r             = s;
      r.drop_final  = 1'b0;
      r.rows_left   = dec;
      r.column_left = width;
      if (dec == 16'd0 || width == 16'd0) begin
         r.phase = PH_DONE;
      end
      return r;
   endfunction

   // counter reload at the start of the body
   always_comb begin
      s_start = state_ff;
      if (start_of_body) begin
         s_start.run_left   = 8'd0;
         s_start.drop_final = 1'b0;
         s_start.row_left   = $signed({2'b00, cfg.image_width});
         if (cfg.decode_mode == MODE_BYTERUN1) begin
            s_start.budget_left = cfg.chunk_length;
            s_start.rows_left   = 16'd0;
            s_start.column_left = 16'd0;
            s_start.phase = (cfg.chunk_length != 32'd0) ? PH_HEADER : PH_DONE;
         end else begin
            s_start.budget_left = 32'd0;
            s_start.rows_left   = cfg.image_height;
            s_start.column_left = cfg.image_width;
            s_start.phase = (cfg.image_height != 16'd0 && cfg.image_width != 16'd0) ?
                            PH_COPY : PH_DONE;
         end
      end
   end

   // header arithmetic: run length, row position and budget charge
   always_comb begin
      literal = ~body_byte[7];
      row_eff = (s_start.row_left <= 18'sd0) ? $signed({2'b00, cfg.image_width}) :
                s_start.row_left;
      run_len = literal ? (body_byte + 8'd1) : (8'd1 - body_byte);
      row_new = row_eff - $signed({10'b0, run_len});
      if (literal) begin
         cost = {1'b0, run_len} + 9'd1;
      end else if (body_byte != HDR_NOOP) begin
         cost = 9'd2;
      end else begin
         cost = 9'd1;
      end
      budget_new = (s_start.budget_left > {23'b0, cost}) ?
                   s_start.budget_left - {23'b0, cost} : 32'd0;
      run_dec  = s_start.run_left - 8'd1;
      col_dec  = s_start.column_left - 16'd1;
      rows_dec = s_start.rows_left - 16'd1;
   end

   // per-phase byte handling
   always_comb begin
      state_in         = s_start;
      res_valid        = 1'b0;
      res.pixel_value  = body_byte;
      res.repeat_count = 8'd1;
      res.last_of_body = 1'b0;
      case (s_start.phase)
         PH_HEADER: begin
            state_in.row_left    = row_eff;
            state_in.budget_left = budget_new;
            if (literal) begin
               state_in.row_left   = row_new;
               state_in.drop_final = (row_new == -18'sd1);
               state_in.run_left   = (row_new == -18'sd1) ? run_len - 8'd1 : run_len;
               state_in.phase      = PH_COPY;
            end else if (body_byte != HDR_NOOP) begin
               state_in.row_left   = row_new;
               state_in.drop_final = 1'b0;
               state_in.run_left   = (row_new == -18'sd1) ? run_len - 8'd1 : run_len;
               state_in.phase      = PH_VALUE;
            end else if (budget_new == 32'd0) begin
               state_in.phase = PH_DONE;
            end
         end
         PH_VALUE: begin
            res_valid        = 1'b1;
            res.repeat_count = s_start.run_left;
            res.last_of_body = (s_start.budget_left == 32'd0);
            state_in         = end_run(s_start);
         end
         PH_COPY: begin
            if (s_start.rows_left == 16'd0) begin
               // literal run of a byterun1 body
               if (s_start.run_left == 8'd0) begin
                  state_in = end_run(s_start);
               end else begin
                  res_valid         = 1'b1;
                  res.last_of_body  = (run_dec == 8'd0) && (s_start.budget_left == 32'd0);
                  state_in.run_left = run_dec;
                  if (run_dec == 8'd0 && !s_start.drop_final) begin
                     state_in = end_run(s_start);
                  end
               end
            end else begin
               // uncompressed row copy
               if (s_start.drop_final || s_start.column_left == 16'd0) begin
                  state_in = end_row(s_start, rows_dec, cfg.image_width);
               end else begin
                  res_valid            = 1'b1;
                  res.last_of_body     = (col_dec == 16'd0) && (s_start.rows_left == 16'd1);
                  state_in.column_left = col_dec;
                  if (col_dec == 16'd0) begin
                     if (cfg.image_width[0]) begin
                        state_in.drop_final = 1'b1;
                     end else begin
                        state_in = end_row(s_start, rows_dec, cfg.image_width);
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         res_valid = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.budget_left <= 32'd0;
         state_ff.row_left    <= 18'sd0;
         state_ff.phase       <= PH_DONE;
         state_ff.run_left    <= 8'd0;
         state_ff.drop_final  <= 1'b0;
         state_ff.rows_left   <= 16'd0;
         state_ff.column_left <= 16'd0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign status.phase = state_ff.phase;

endmodule

// ===== rtl/brd_out_buf.sv =====
// two-entry result buffer: output register plus skid register
// depends on brd_pkg
module brd_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  brd_pkg::rsp_type        in_data,
   input  logic                    out_stall,
   output logic                    out_valid,
   output brd_pkg::rsp_type        out_data,
   output brd_pkg::buf_status_type status
);
   import brd_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   // drain the output register, refill from skid, then place the new result
   always_comb begin
      take          = main_valid_ff & ~out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
      if (in_valid) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = in_data;
         end
      end
   end

   // occupancy flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid         = main_valid_ff;
   assign out_data          = main_ff;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

// ===== rtl/byterun1_row_decoder_unit.sv =====
// byterun1 row decoder, top level: configuration registers, core, result buffer
// depends on brd_pkg, brd_core, brd_out_buf and assert_macros.svh
//
// Usage
//   req_ channel: one body byte per transaction, with req_start_of_body set on
//   the first byte of a body to reload every counter from the registers.
//   rsp_ channel: one pixel run per transaction (value, repeat count, and a
//   flag on the final run of the body). Header and pad bytes give no result.
//   csr_ channel: register writes, always ready; write only while idle.
// Timing
//   Bytes are accepted at one per cycle while req_stall is low; a result, if
//   any, is registered in the result buffer before the rsp_ ports. The core's
//   counter logic handles the whole byte in the cycle it is accepted.
// Stall
//   Results sit in a two-entry buffer. While rsp_stall is high one further
//   result can be absorbed; req_stall rises once the skid entry is occupied
//   and falls as soon as it drains.
// Reset
//   Registers take their defaults (320 x 200, byterun1, zero budget) and the
//   core enters the done phase: bytes are ignored until req_start_of_body.
`include "assert_macros.svh"

module byterun1_row_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_of_body,
   input  logic [7:0]             req_body_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_pixel_value,
   output logic [7:0]             rsp_repeat_count,
   output logic                   rsp_last_of_body,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  brd_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data
);
   import brd_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            req_accept;
   logic            res_valid;
   rsp_type         res;
   rsp_type         rsp_data;
   core_status_type core_status;
   buf_status_type  buf_status;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_data[15:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_data[15:0];
            CSR_DECODE_MODE:  cfg_in.decode_mode  = csr_data[0];
            CSR_CHUNK_LENGTH: cfg_in.chunk_length = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= WIDTH_RESET;
         cfg_ff.image_height <= HEIGHT_RESET;
         cfg_ff.decode_mode  <= MODE_RESET;
         cfg_ff.chunk_length <= CHUNK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign req_stall  = buf_status.skid_valid;
   assign req_accept = req_valid & ~req_stall;

   brd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .start_of_body (req_start_of_body),
      .body_byte     (req_body_byte),
      .cfg           (cfg_ff),
      .res_valid     (res_valid),
      .res           (res),
      .status        (core_status)
   );

   brd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .status    (buf_status)
   );

   assign rsp_pixel_value  = rsp_data.pixel_value;
   assign rsp_repeat_count = rsp_data.repeat_count;
   assign rsp_last_of_body = rsp_data.last_of_body;

   // checks
   `ASSERT_IMPLIES(a_skid_behind_main, clock, reset, buf_status.skid_valid,
      buf_status.main_valid, "skid entry held while output register empty")
   `ASSERT_NEXT(a_stalled_result_blocks, clock, reset,
      res_valid && rsp_valid && rsp_stall, req_stall,
      "result taken into a full, stalled output register did not raise req_stall")
   `ASSERT_IMPLIES(a_done_is_silent, clock, reset,
      req_accept && !req_start_of_body && core_status.phase == PH_DONE, !res_valid,
      "result produced in the done phase")
   `ASSERT_IMPLIES(a_count_nonzero, clock, reset, rsp_valid,
      rsp_repeat_count != 8'd0, "pixel run with zero repeat count")

endmodule

// ===== sim/brd_run_checker.sv =====
// pixel run checker for the byterun1 row decoder: follows the csr_, req_ and rsp_ channels
// keeps its own copy of the registers and the decoder state; depends on brd_pkg
module brd_run_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_start_of_body,
   input  logic [7:0]             req_body_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [7:0]             rsp_pixel_value,
   input  logic [7:0]             rsp_repeat_count,
   input  logic                   rsp_last_of_body,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  brd_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   leftover_check,
   output int                     runs_pending,
   output int                     error_count
);
   import brd_pkg::*;

   localparam int PRINT_LIMIT = 100;

   // register copy
   cfg_type cfg;

   // decoder state
   longint    budget_left;
   int        row_left;
   phase_type phase;
   int        run_left;
   logic      drop_final;
   int        rows_left;
   int        column_left;

   // pixel runs predicted but not yet delivered
   rsp_type pixel_runs_due[$];
   rsp_type predicted;
   rsp_type oldest;
   logic    produced;
   logic    leftovers_reported;

   task automatic report_failure(input string text);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: %s", $time, text);
   endtask

   // budget is charged per run and saturates at zero
   task automatic charge(input longint cost);
      budget_left = (budget_left > cost) ? budget_left - cost : 0;
   endtask

   task automatic end_run();
      drop_final = 1'b0;
      run_left   = 0;
      phase      = (budget_left > 0) ? PH_HEADER : PH_DONE;
   endtask

   task automatic end_row();
      drop_final  = 1'b0;
      rows_left   = (rows_left - 1) & 16'hFFFF;
      column_left = int'(cfg.image_width);
      if (rows_left == 0 || column_left == 0)
         phase = PH_DONE;
   endtask

   // one body byte in, at most one pixel run out
   task automatic decode_body_byte(input logic first, input logic [7:0] b,
                                   output logic made, output rsp_type run);
      int hdr;
      int span;
      made = 1'b0;
      run  = '0;

      // start of body reloads every counter from the registers
      if (first) begin
         run_left   = 0;
         drop_final = 1'b0;
         row_left   = int'(cfg.image_width);
         if (cfg.decode_mode == MODE_BYTERUN1) begin
            budget_left = longint'(cfg.chunk_length);
            rows_left   = 0;
            column_left = 0;
            phase       = (budget_left > 0) ? PH_HEADER : PH_DONE;
         end else begin
            budget_left = 0;
            rows_left   = int'(cfg.image_height);
            column_left = int'(cfg.image_width);
            phase       = (rows_left != 0 && column_left != 0) ? PH_COPY : PH_DONE;
         end
      end

      case (phase)
         PH_HEADER: begin
            hdr = (b >= 8'd128) ? int'(b) - 256 : int'(b);
            if (row_left <= 0)
               row_left = int'(cfg.image_width);
            if (hdr >= 0) begin
               // literal run, last byte dropped when it is the pad
               span = hdr + 1;
               charge(span + 1);
               row_left   -= span;
               drop_final = (row_left == -1);
               if (drop_final)
                  span--;
               run_left = span;
               phase    = PH_COPY;
            end else if (b != HDR_NOOP) begin
               // repeat run, count cut by one when it covers the pad
               span = 1 - hdr;
               charge(2);
               row_left -= span;
               if (row_left == -1)
                  span--;
               run_left   = span;
               drop_final = 1'b0;
               phase      = PH_VALUE;
            end else begin
               charge(1);
               if (budget_left == 0)
                  phase = PH_DONE;
            end
         end
         PH_VALUE: begin
            run.pixel_value  = b;
            run.repeat_count = 8'(run_left);
            run.last_of_body = (budget_left == 0);
            made = 1'b1;
            end_run();
         end
         PH_COPY: begin
            if (rows_left == 0) begin
               // literal bytes of a byterun1 run
               if (run_left == 0) begin
                  end_run();
               end else begin
                  run_left--;
                  run.pixel_value  = b;
                  run.repeat_count = 8'd1;
                  run.last_of_body = (run_left == 0) && (budget_left == 0);
                  made = 1'b1;
                  if (run_left == 0 && !drop_final)
                     end_run();
               end
            end else if (drop_final || column_left == 0) begin
               // pad byte after an odd row
               end_row();
            end else begin
               // uncompressed row copy
               column_left--;
               run.pixel_value  = b;
               run.repeat_count = 8'd1;
               run.last_of_body = (column_left == 0) && (rows_left == 1);
               made = 1'b1;
               if (column_left == 0) begin
                  if (cfg.image_width[0])
                     drop_final = 1'b1;
                  else
                     end_row();
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.image_width    = WIDTH_RESET;
         cfg.image_height   = HEIGHT_RESET;
         cfg.decode_mode    = MODE_RESET;
         cfg.chunk_length   = CHUNK_RESET;
         budget_left        = 0;
         row_left           = 0;
         phase              = PH_DONE;
         run_left           = 0;
         drop_final         = 1'b0;
         rows_left          = 0;
         column_left        = 0;
         leftovers_reported = 1'b0;
         pixel_runs_due.delete();
      end else begin
         // result transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pixel_runs_due.size() == 0) begin
               report_failure($sformatf("unexpected pixel run: value %0d count %0d last %0d",
                                        rsp_pixel_value, rsp_repeat_count, rsp_last_of_body));
            end else begin
               oldest = pixel_runs_due.pop_front();
               if (rsp_pixel_value !== oldest.pixel_value)
                  report_failure($sformatf("pixel_value: got %0d, expected %0d",
                                           rsp_pixel_value, oldest.pixel_value));
               if (rsp_repeat_count !== oldest.repeat_count)
                  report_failure($sformatf("repeat_count: got %0d, expected %0d",
                                           rsp_repeat_count, oldest.repeat_count));
               if (rsp_last_of_body !== oldest.last_of_body)
                  report_failure($sformatf("last_of_body: got %0d, expected %0d",
                                           rsp_last_of_body, oldest.last_of_body));
            end
         end

         // body byte transaction
         if (req_valid && !req_stall) begin
            decode_body_byte(req_start_of_body, req_body_byte, produced, predicted);
            if (produced)
               pixel_runs_due.push_back(predicted);
         end

         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg.image_width  = csr_data[15:0];
               CSR_IMAGE_HEIGHT: cfg.image_height = csr_data[15:0];
               CSR_DECODE_MODE:  cfg.decode_mode  = csr_data[0];
               CSR_CHUNK_LENGTH: cfg.chunk_length = csr_data;
               default: ;
            endcase
         end

         // predictions still waiting at the end of the run
         if (leftover_check && !leftovers_reported) begin
            leftovers_reported = 1'b1;
            foreach (pixel_runs_due[i])
               report_failure($sformatf("pixel run never delivered: value %0d count %0d",
                                        pixel_runs_due[i].pixel_value,
                                        pixel_runs_due[i].repeat_count));
         end
      end
      runs_pending <= pixel_runs_due.size();
   end

endmodule

// ===== sim/tb_byterun1_row_decoder_unit.sv =====
// testbench top for the byterun1 row decoder: clock, reset, stimulus and verdict
// drives byterun1_row_decoder_unit and hands every channel to brd_run_checker; uses brd_pkg
module tb_byterun1_row_decoder_unit;
   import brd_pkg::*;

   localparam int RANDOM_ITEMS   = 1000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_pattern_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic          req_start_of_body;
   logic [7:0]    req_body_byte;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [7:0]    rsp_pixel_value;
   logic [7:0]    rsp_repeat_count;
   logic          rsp_last_of_body;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [31:0]   csr_data;
   logic          leftover_check;
   int            runs_pending;
   int            error_count;

   int   bytes_sent   = 0;
   int   burst_left   = 1;
   int   quiet_cycles = 0;
   logic hold_wanted  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byterun1_row_decoder_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_of_body (req_start_of_body),
      .req_body_byte     (req_body_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_last_of_body  (rsp_last_of_body),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   brd_run_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_of_body (req_start_of_body),
      .req_body_byte     (req_body_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_last_of_body  (rsp_last_of_body),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .leftover_check    (leftover_check),
      .runs_pending      (runs_pending),
      .error_count       (error_count)
   );

   // one body byte transaction, sent in bursts with random gaps
   task automatic send_byte(input logic first, input logic [7:0] b);
      req_valid         <= 1'b1;
      req_start_of_body <= first;
      req_body_byte     <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic put_register(input csr_index_type index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input logic [15:0] width, input logic [15:0] height,
                               input logic mode, input logic [31:0] chunk);
      put_register(CSR_IMAGE_WIDTH, {16'd0, width});
      put_register(CSR_IMAGE_HEIGHT, {16'd0, height});
      put_register(CSR_DECODE_MODE, {31'd0, mode});
      put_register(CSR_CHUNK_LENGTH, chunk);
      csr_valid <= 1'b0;
   endtask

   // let every predicted run arrive, then allow the block to go quiet
   task automatic drain_decoder();
      req_valid <= 1'b0;
      do @(posedge clock); while (runs_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // well-formed runs with random content, plus the odd stray byte
   task automatic send_byterun1_body(input int plan_len);
      int   sent;
      int   kind;
      int   span;
      logic first;
      sent  = 0;
      first = 1'b1;
      while (sent < plan_len) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            span = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            send_byte(first, 8'(span));
            repeat (span + 1) send_byte(1'b0, 8'($urandom));
            sent += span + 2;
         end else if (kind < 90) begin
            span = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(2, 9);
            send_byte(first, 8'(257 - span));
            send_byte(1'b0, 8'($urandom));
            sent += 2;
         end else if (kind < 95) begin
            send_byte(first, HDR_NOOP);
            sent += 1;
         end else begin
            send_byte(first, 8'($urandom));
            sent += 1;
         end
         first = 1'b0;
      end
   endtask

   // receiver stall patterns, with one long hold-off on request
   initial begin : receiver
      stall_pattern_type pattern;
      int                len;
      int                held;
      held = 0;
      rsp_stall <= 1'b0;
      forever begin
         pattern = stall_pattern_type'($urandom_range(0, 3));
         len     = $urandom_range(10, 120);
         repeat (len) begin
            @(posedge clock);
            if (hold_wanted && held < HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               held++;
            end else begin
               case (pattern)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
                  STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
                  default:     rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          random_start;
      int          plan_len;
      int          count;
      int          bodies;
      logic        mode;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] chunk;

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_start_of_body <= 1'b0;
      req_body_byte     <= 8'd0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_IMAGE_WIDTH;
      csr_data          <= 32'd0;
      leftover_check    <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // uncompressed, width 1: pad byte after each row, last on the final pixel
      write_config(16'd1, 16'd2, MODE_RAW, 32'd0);
      send_byte(1'b1, 8'h00);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'h5A);
      drain_decoder();

      // byterun1, odd width: literal, repeat cut at the pad, no-op, longest repeat,
      // literal losing its pad byte, budget running out, byte after the end
      write_config(16'd5, 16'hFFFF, MODE_BYTERUN1, 32'd16);
      send_byte(1'b1, 8'h02);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'h80);
      send_byte(1'b0, 8'hFE);
      send_byte(1'b0, 8'h55);
      send_byte(1'b0, HDR_NOOP);
      send_byte(1'b0, 8'h81);
      send_byte(1'b0, 8'h7F);
      send_byte(1'b0, 8'h05);
      for (int i = 1; i <= 6; i++)
         send_byte(1'b0, 8'(i));
      send_byte(1'b0, 8'h00);
      drain_decoder();

      // zero width: a literal of one byte gives nothing and swallows its byte
      write_config(16'd0, 16'd1, MODE_BYTERUN1, 32'd2);
      send_byte(1'b1, 8'h00);
      send_byte(1'b0, 8'hAA);
      drain_decoder();

      // body ending on a no-op
      write_config(16'd4, 16'd1, MODE_BYTERUN1, 32'd1);
      send_byte(1'b1, HDR_NOOP);
      drain_decoder();

      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_ITEMS) begin
         mode = ($urandom_range(0, 9) < 7) ? MODE_BYTERUN1 : MODE_RAW;
         if (!hold_wanted && bytes_sent - random_start > 300) begin
            // long receiver hold-off while a large body keeps coming
            hold_wanted = 1'b1;
            write_config(16'd7, 16'd1, MODE_BYTERUN1, 32'hFFFF_FFFF);
            send_byterun1_body(150);
         end else if (mode == MODE_BYTERUN1) begin
            case ($urandom_range(0, 6))
               0:       width = 16'd1;
               1:       width = 16'hFFFF;
               2:       width = 16'($urandom_range(13, 400));
               default: width = 16'($urandom_range(1, 12));
            endcase
            height   = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
            plan_len = $urandom_range(4, 48);
            case ($urandom_range(0, 9))
               5, 6:    chunk = 32'($urandom_range(1, 2 * plan_len));
               7:       chunk = 32'hFFFF_FFFF;
               8:       chunk = 32'd0;
               9:       chunk = 32'($urandom_range(1, 3));
               default: chunk = 32'(plan_len);
            endcase
            write_config(width, height, MODE_BYTERUN1, chunk);
            bodies = $urandom_range(1, 3);
            repeat (bodies) begin
               send_byterun1_body(plan_len);
               repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom));
            end
         end else begin
            width  = ($urandom_range(0, 4) == 0) ? 16'd1 : 16'($urandom_range(1, 9));
            height = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4));
            write_config(width, height, MODE_RAW, 32'($urandom));
            bodies = $urandom_range(1, 3);
            repeat (bodies) begin
               if (height == 16'hFFFF)
                  count = $urandom_range(10, 40);
               else
                  count = (int'(width) + int'(width[0])) * int'(height);
               if ($urandom_range(0, 5) == 0)
                  count = $urandom_range(1, count);
               for (int i = 0; i < count; i++)
                  send_byte(i == 0, 8'($urandom));
               repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom));
            end
         end
         drain_decoder();
      end

      // report anything still owed, then the verdict
      leftover_check <= 1'b1;
      @(posedge clock);
      @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== byterun1_row_decoder_unit.f =====
+incdir+rtl
rtl/brd_pkg.sv
rtl/brd_core.sv
rtl/brd_out_buf.sv
rtl/byterun1_row_decoder_unit.sv
sim/brd_run_checker.sv
sim/tb_byterun1_row_decoder_unit.sv
